// ----- design/sha_pkg.sv -----
package sha_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
        logic        error;
    } t_out_item;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [60:0] COUNT_MAX = {61{1'b1}};
    localparam logic [7:0]  PAD_BYTE  = 8'h80;

    // Byte-source select codes for the block buffer load
    localparam logic [1:0] LD_DATA = 2'd0;
    localparam logic [1:0] LD_PAD  = 2'd1;
    localparam logic [1:0] LD_ZERO = 2'd2;
    localparam logic [1:0] LD_LEN  = 2'd3;

    typedef struct packed {
        logic       load_en;     // write one byte into the block buffer
        logic [1:0] load_sel;
        logic [5:0] load_addr;
        logic       count_inc;
        logic       comp_start;  // copy the hash words into the round registers
        logic       round_en;
        logic [5:0] round_idx;
        logic       comp_done;   // add round variables into the hash words
        logic       hash_init;   // restore initial hash and clear the count
        logic [2:0] out_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [60:0] byte_count;
        logic [31:0] out_word;
    } t_dp_status;

    function automatic logic [31:0] initial_hash(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[r];
    endfunction

endpackage

// ----- design/sha_datapath.sv -----
module sha_datapath
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [7:0] i_data_byte,
    output t_dp_status o_status
);

    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [31:0] r_hash [8];
    logic [60:0] r_count;

    logic [7:0]  load_byte;
    logic [63:0] bit_len;
    logic [31:0] w15, w2, s0, s1, w_new, w_cur;
    logic [31:0] big0, big1, ch, maj, t1, t2;

    assign bit_len = {r_count, 3'b000};

    always_comb begin
        unique case (i_cmd.load_sel)
            LD_DATA: load_byte = i_data_byte;
            LD_PAD:  load_byte = PAD_BYTE;
            LD_ZERO: load_byte = 8'h00;
            LD_LEN:  load_byte = bit_len[8*(7 - i_cmd.load_addr[2:0]) +: 8];
            default: load_byte = 8'h00;
        endcase
    end

    always_comb begin
        w15   = r_w[1];
        w2    = r_w[14];
        s0    = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        s1    = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        w_cur = r_w[0];
        big1  = {r_e[5:0], r_e[31:6]} ^ {r_e[10:0], r_e[31:11]} ^ {r_e[24:0], r_e[31:25]};
        ch    = (r_e & r_f) ^ (~r_e & r_g);
        t1    = r_h + big1 + ch + round_k(i_cmd.round_idx) + w_cur;
        big0  = {r_a[1:0], r_a[31:2]} ^ {r_a[12:0], r_a[31:13]} ^ {r_a[21:0], r_a[31:22]};
        maj   = (r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c);
        t2    = big0 + maj;
    end

    // Bytes land big-endian straight in the schedule window; input is held
    // during compression, so every byte of a block is rewritten before it starts.
    // Schedule window shifts: slot 0 always holds the word for this round
    always_ff @(posedge i_clk) begin
        if (i_cmd.comp_start) begin
            r_a <= r_hash[0];
            r_b <= r_hash[1];
            r_c <= r_hash[2];
            r_d <= r_hash[3];
            r_e <= r_hash[4];
            r_f <= r_hash[5];
            r_g <= r_hash[6];
            r_h <= r_hash[7];
        end else if (i_cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
            r_h <= r_g;
            r_g <= r_f;
            r_f <= r_e;
            r_e <= r_d + t1;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_a;
            r_a <= t1 + t2;
        end else if (i_cmd.load_en) begin
            unique case (i_cmd.load_addr[1:0])
                2'd0: r_w[i_cmd.load_addr[5:2]][31:24] <= load_byte;
                2'd1: r_w[i_cmd.load_addr[5:2]][23:16] <= load_byte;
                2'd2: r_w[i_cmd.load_addr[5:2]][15:8]  <= load_byte;
                default: r_w[i_cmd.load_addr[5:2]][7:0] <= load_byte;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.hash_init) begin
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= initial_hash(3'(i));
            end
            r_count <= '0;
        end else begin
            if (i_cmd.comp_done) begin
                r_hash[0] <= r_hash[0] + r_a;
                r_hash[1] <= r_hash[1] + r_b;
                r_hash[2] <= r_hash[2] + r_c;
                r_hash[3] <= r_hash[3] + r_d;
                r_hash[4] <= r_hash[4] + r_e;
                r_hash[5] <= r_hash[5] + r_f;
                r_hash[6] <= r_hash[6] + r_g;
                r_hash[7] <= r_hash[7] + r_h;
            end
            if (i_cmd.count_inc) begin
                r_count <= r_count + 61'd1;
            end
        end
    end

    assign o_status.byte_count = r_count;
    assign o_status.out_word   = r_hash[i_cmd.out_idx];

endmodule

// ----- design/sha_control.sv -----
module sha_control
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_item   i_in_data,
    output logic       o_in_stall,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output t_out_item  o_out_data,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;   // fill zeros and length
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;
    localparam logic [2:0] ST_ERR   = 3'd6;

    logic [2:0] r_state, n_state;
    logic [5:0] r_fill, n_fill;
    logic [5:0] r_round, n_round;
    logic [2:0] r_idx, n_idx;
    logic       r_fin, n_fin;     // finishing the message
    logic       r_final, n_final; // this compression is the last one
    logic       accept, emit_take;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign emit_take  = o_out_valid && !i_out_stall;

    assign o_out_valid = (r_state == ST_EMIT) || (r_state == ST_ERR);
    always_comb begin
        o_out_data.digest_word = (r_state == ST_EMIT) ? i_status.out_word : 32'd0;
        o_out_data.word_index  = (r_state == ST_EMIT) ? r_idx : 3'd0;
        o_out_data.last        = (r_state == ST_ERR) || (r_idx == 3'd7);
        o_out_data.error       = (r_state == ST_ERR);
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_round = r_round;
        n_idx   = r_idx;
        n_fin   = r_fin;
        n_final = r_final;
        o_cmd   = '0;
        o_cmd.round_idx = r_round;
        o_cmd.out_idx   = r_idx;
        o_cmd.load_addr = r_fill;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_data.kind == KIND_BYTE) begin
                        if (i_status.byte_count == COUNT_MAX) begin
                            n_state = ST_ERR;
                        end else begin
                            o_cmd.load_en   = 1'b1;
                            o_cmd.load_sel  = LD_DATA;
                            o_cmd.count_inc = 1'b1;
                            n_fill = r_fill + 6'd1;
                            if (r_fill == 6'd63) begin
                                n_state = ST_START;
                                n_fin   = 1'b0;
                            end
                        end
                    end else begin
                        o_cmd.load_en  = 1'b1;
                        o_cmd.load_sel = LD_PAD;
                        n_fill  = r_fill + 6'd1;
                        n_fin   = 1'b1;
                        n_state = ST_PAD;
                        n_final = (r_fill < 6'd56);
                        if (r_fill == 6'd63) begin
                            n_state = ST_START;
                        end
                    end
                end
            end
            ST_PAD: begin
                o_cmd.load_en  = 1'b1;
                o_cmd.load_sel = (r_final && r_fill >= 6'd56) ? LD_LEN : LD_ZERO;
                n_fill = r_fill + 6'd1;
                if (r_fill == 6'd63) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                o_cmd.comp_start = 1'b1;
                n_round = 6'd0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                o_cmd.comp_done = 1'b1;
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_final) begin
                    n_idx   = 3'd0;
                    n_state = ST_EMIT;
                end else begin
                    n_final = 1'b1;
                    n_state = ST_PAD;
                end
            end
            ST_EMIT: begin
                if (emit_take) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        o_cmd.hash_init = 1'b1;
                        n_fill  = 6'd0;
                        n_fin   = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (emit_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_round <= '0;
            r_idx   <= '0;
            r_fin   <= 1'b0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_round <= n_round;
            r_idx   <= n_idx;
            r_fin   <= n_fin;
            r_final <= n_final;
        end
    end

`ifndef ASSERT_OFF
    a_round_in_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.round_en |-> r_state == ST_ROUND)
        else $error("round enable outside round state");
    a_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_round == 6'd63) |=> r_state == ST_ADD)
        else $error("compression did not end after 64 rounds");
    a_start_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_START) |-> r_fill == 6'd0)
        else $error("compression started on partial block");
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ERR && !i_out_stall) |=> r_state == ST_IDLE)
        else $error("error transaction repeated");
`endif

endmodule

// ----- design/sha256_stream_hasher.sv -----
// SHA-256 hasher fed one byte per transaction. A message byte that completes
// a 64-byte block stalls the input while the single round unit runs 64
// rounds (one per cycle) plus load and final add. A finish transaction writes
// padding one byte per cycle up to the block end, runs one or two
// compressions, then presents the eight digest words, one per transaction,
// after which the state is back to the initial hash. A byte arriving at the
// maximum length yields one error transaction.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    sha_control u_control (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sha_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data_byte (i_in_data.data_byte),
        .o_status    (status)
    );

endmodule

// ----- verif/sha256_stream_hasher_checker.sv -----
`timescale 1ns / 100ps

module sha256_stream_hasher_checker
    import sha_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_mismatches,
    output int        o_pending,
    output int        o_words_seen
);

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0] chain [8];
    logic [7:0]  msg_block [64];
    logic [60:0] msg_len;
    t_out_item   digest_q [$];

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int r = 0; r < 16; r++)
            w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
        for (int r = 16; r < 64; r++) begin
            s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
            s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
            w[r] = w[r-16] + s0 + w[r-7] + s1;
        end
        for (int i = 0; i < 8; i++)
            v[i] = chain[i];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + w[r];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--)
                v[i] = v[i-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++)
            chain[i] = START_HASH[i];
        msg_len = '0;
    endfunction

    function automatic void absorb_item(input t_in_item it);
        logic [63:0] bit_len;
        int          fill;
        t_out_item   res;
        fill = int'(msg_len[5:0]);
        if (it.kind == KIND_BYTE) begin
            if (msg_len == COUNT_MAX) begin
                res = '{digest_word: '0, word_index: '0, last: 1'b1, error: 1'b1};
                digest_q.push_back(res);
                return;
            end
            msg_block[fill] = it.data_byte;
            msg_len = msg_len + 61'd1;
            if (fill == 63)
                compress_block();
            return;
        end
        bit_len = {msg_len, 3'b000};
        msg_block[fill] = PAD_BYTE;
        fill++;
        // no room for the length: spill into one more block
        if (fill > 56) begin
            for (int i = fill; i < 64; i++)
                msg_block[i] = 8'h00;
            compress_block();
            fill = 0;
        end
        for (int i = fill; i < 56; i++)
            msg_block[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            msg_block[63-i] = bit_len[8*i +: 8];
        compress_block();
        for (int i = 0; i < 8; i++) begin
            res.digest_word = chain[i];
            res.word_index  = 3'(i);
            res.last        = (i == 7);
            res.error       = 1'b0;
            digest_q.push_back(res);
        end
        restart_message();
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        o_mismatches++;
    endtask

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_words_seen = 0;
        restart_message();
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                absorb_item(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                o_words_seen++;
                if (digest_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction %h", i_out_data));
                end else begin
                    want = digest_q.pop_front();
                    if (i_out_data.digest_word !== want.digest_word)
                        report_mismatch($sformatf("word %0d: got %h want %h",
                            want.word_index, i_out_data.digest_word, want.digest_word));
                    if (i_out_data.word_index !== want.word_index)
                        report_mismatch($sformatf("word_index got %0d want %0d",
                            i_out_data.word_index, want.word_index));
                    if (i_out_data.last !== want.last)
                        report_mismatch($sformatf("last on word %0d got %b want %b",
                            want.word_index, i_out_data.last, want.last));
                    if (i_out_data.error !== want.error)
                        report_mismatch($sformatf("error on word %0d got %b want %b",
                            want.word_index, i_out_data.error, want.error));
                end
            end
            o_pending = digest_q.size();
        end
    end

endmodule

// ----- verif/sha256_stream_hasher_tb.sv -----
`timescale 1ns / 100ps

module sha256_stream_hasher_tb;
    import sha_pkg::*;

    localparam int MSG_BYTES   = 420;
    localparam int CYCLE_LIMIT = 600000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    int   mismatches, pending, words_seen;
    int   send_idle_pct, recv_stall_pct;
    int   bytes_sent, messages_sent, cycles;
    logic in_fire_q;

    sha256_stream_hasher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    sha256_stream_hasher_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_words_seen (words_seen)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        in_fire_q <= i_in_valid && !o_in_stall;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic kind, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = '{kind: kind, data_byte: b};
        do
            @(negedge i_clk);
        while (!in_fire_q);
        if (kind == KIND_BYTE)
            bytes_sent++;
        else
            messages_sent++;
        // drop valid only if no item follows right away; next call overrides it
        if (bytes_sent >= MSG_BYTES && kind == KIND_FINISH)
            i_in_valid = 1'b0;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_item(KIND_BYTE, 8'($urandom_range(0, 255)));
        send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic set_phase();
        if (bytes_sent < MSG_BYTES / 3) begin
            send_idle_pct  = 34;
            recv_stall_pct = 51;
        end else if (bytes_sent < 2 * MSG_BYTES / 3) begin
            send_idle_pct  = 51;
            recv_stall_pct = 34;
        end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    endtask

    initial begin
        int len;
        int waited;
        int edge_lens [8];
        edge_lens      = '{55, 56, 57, 63, 64, 65, 119, 120};
        cycles         = 0;
        bytes_sent     = 0;
        messages_sent  = 0;
        send_idle_pct  = 34;
        recv_stall_pct = 51;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_stall    = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // empty message, "abc", single all-ones and all-zero bytes
        send_item(KIND_FINISH, 8'hff);
        send_item(KIND_BYTE, 8'h61);
        send_item(KIND_BYTE, 8'h62);
        send_item(KIND_BYTE, 8'h63);
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_BYTE, 8'hff);
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_FINISH, 8'hff);

        while (bytes_sent < MSG_BYTES) begin
            set_phase();
            if ($urandom_range(0, 99) < 25)
                len = edge_lens[$urandom_range(0, 7)];
            else
                len = $urandom_range(0, 40);
            send_message(len);
        end
        i_in_valid = 1'b0;

        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (200) @(negedge i_clk);

        $display("sent %0d messages (%0d bytes, padding across block boundaries)",
            messages_sent, bytes_sent);
        $display("checked %0d digest words under sender gaps and receiver stalls",
            words_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d words missing", mismatches, pending);
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/sha_pkg.sv
design/sha_datapath.sv
design/sha_control.sv
design/sha256_stream_hasher.sv
verif/sha256_stream_hasher_checker.sv
verif/sha256_stream_hasher_tb.sv
